// File: design/tcw_pkg.sv
// tcw_pkg: shared constants, types and phase tables for the text console writer
// used by tcw_ram-free logic in text_console_writer_unit and by tcw_checker
package tcw_pkg;

    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int TAB_STOP = 8;
    localparam int CELLS    = COLUMNS * ROWS;

    localparam int FUNC_W = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int OFF_W  = 11;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int WIDE_W = OFF_W + 1;
    localparam int PH_W   = $clog2(TAB_STOP);
    localparam int STEP_W = $clog2(TAB_STOP + 1);
    localparam int CELL_W = CHAR_W + ATTR_W;

    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;

    typedef enum logic [FUNC_W-1:0] {
        F_PRINT = 2'd0,
        F_SET   = 2'd1,
        F_CLEAR = 2'd2,
        F_READ  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCR_RD,
        S_SCR_MV,
        S_BLANK,
        S_RESP
    } t_state;

    typedef logic [PH_W-1:0] t_phase;
    typedef logic [COLUMNS-1:0][PH_W-1:0] t_col_tab;
    typedef logic [ROWS:0][PH_W-1:0] t_row_tab;

    // linear offset modulo tab stop, split into column and row-start parts
    function automatic t_col_tab build_col_tab();
        t_col_tab tab;
        for (int i = 0; i < COLUMNS; i++) begin
            tab[i] = t_phase'(i % TAB_STOP);
        end
        return tab;
    endfunction

    function automatic t_row_tab build_row_tab();
        t_row_tab tab;
        for (int i = 0; i <= ROWS; i++) begin
            tab[i] = t_phase'((i * COLUMNS) % TAB_STOP);
        end
        return tab;
    endfunction

    localparam t_col_tab COL_PHASE = build_col_tab();
    localparam t_row_tab ROW_PHASE = build_row_tab();

endpackage

// File: design/tcw_ram.sv
// tcw_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/text_console_writer_unit.sv
// text console writer: 80x25 cell store with cursor, print, set, clear, read
// a print without scroll and a set cursor go from idle straight to the result state, a read
// passes S_READ first; a new word is taken only while idle. A clear walks every cell; a scroll
// moves 1920 cells and blanks 80, one ram write per cycle in each walk
// reset: cursor home, attribute 7, cell store not cleared (undefined until a clear)
// depends on tcw_pkg and tcw_ram
module text_console_writer_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [tcw_pkg::FUNC_W-1:0]  i_func,
    input  logic [tcw_pkg::CHAR_W-1:0]  i_char_code,
    input  logic [tcw_pkg::COL_W-1:0]   i_pos_x,
    input  logic [tcw_pkg::ROW_W-1:0]   i_pos_y,
    input  logic [tcw_pkg::OFF_W-1:0]   i_cell_addr,
    input  logic                        i_cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0]  i_cfg_wdata,
    output logic                        o_valid,
    output logic [tcw_pkg::OFF_W-1:0]   o_cursor_offset,
    output logic [tcw_pkg::COL_W-1:0]   o_cursor_col,
    output logic [tcw_pkg::ROW_W-1:0]   o_cursor_row,
    output logic                        o_scrolled,
    output logic [tcw_pkg::CHAR_W-1:0]  o_read_char,
    output logic [tcw_pkg::ATTR_W-1:0]  o_read_attr
);

    import tcw_pkg::*;

    t_state r_state, n_state;

    logic [OFF_W-1:0]  r_pos, n_pos;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    t_phase            r_phase, n_phase;
    logic              r_scrolled, n_scrolled;
    logic              r_rd_ok, n_rd_ok;
    logic [CELL_W-1:0] r_rd_data, n_rd_data;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic [ATTR_W-1:0] r_attr;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    logic              accept;
    logic [WIDE_W-1:0] wide_pos;
    logic [COL_W-1:0]  px_c;
    logic [ROW_W-1:0]  py_c;
    logic [STEP_W-1:0] tab_step;
    logic [COL_W:0]    tab_col;
    logic [PH_W:0]     set_phase;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign accept = start && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_phase <= '0;
            r_attr  <= ATTR_RESET;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_col   <= n_col;
            r_row   <= n_row;
            r_phase <= n_phase;
            if (i_cfg_we) begin
                r_attr <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_scrolled <= n_scrolled;
        r_rd_ok    <= n_rd_ok;
        r_rd_data  <= n_rd_data;
        r_idx      <= n_idx;
    end

    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_col      = r_col;
        n_row      = r_row;
        n_phase    = r_phase;
        n_scrolled = r_scrolled;
        n_rd_ok    = r_rd_ok;
        n_rd_data  = r_rd_data;
        n_idx      = r_idx;

        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = {CH_SPACE, r_attr};
        ram_raddr = '0;

        wide_pos  = {1'b0, r_pos};
        px_c      = (i_pos_x > COL_W'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1) : i_pos_x;
        py_c      = (i_pos_y > ROW_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : i_pos_y;
        tab_step  = STEP_W'(TAB_STOP) - STEP_W'(r_phase);
        tab_col   = {1'b0, r_col} + (COL_W + 1)'(tab_step);
        set_phase = {1'b0, ROW_PHASE[py_c]} + {1'b0, COL_PHASE[px_c]};

        unique case (r_state)
            S_IDLE: begin
                // read port serves the read-cell op, out-of-screen reads give zero
                ram_raddr = (i_cell_addr < OFF_W'(CELLS)) ? ADDR_W'(i_cell_addr) : '0;
                if (accept) begin
                    n_scrolled = 1'b0;
                    n_rd_ok    = 1'b0;
                    n_rd_data  = '0;
                    n_state    = S_RESP;
                    unique case (t_func'(i_func))
                        F_PRINT: begin
                            if (i_char_code == CH_NEWLINE) begin
                                wide_pos = {1'b0, r_pos} + WIDE_W'(COLUMNS) - WIDE_W'(r_col);
                                n_col    = '0;
                                n_row    = r_row + ROW_W'(1);
                                n_phase  = ROW_PHASE[r_row + ROW_W'(1)];
                            end else if (i_char_code == CH_TAB) begin
                                wide_pos = {1'b0, r_pos} + WIDE_W'(tab_step);
                                n_phase  = '0;
                                if (tab_col >= (COL_W + 1)'(COLUMNS)) begin
                                    n_col = COL_W'(tab_col - (COL_W + 1)'(COLUMNS));
                                    n_row = r_row + ROW_W'(1);
                                end else begin
                                    n_col = COL_W'(tab_col);
                                end
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = ADDR_W'(r_pos);
                                ram_wdata = {i_char_code, r_attr};
                                wide_pos  = {1'b0, r_pos} + WIDE_W'(1);
                                n_phase   = (r_phase == t_phase'(TAB_STOP - 1)) ?
                                            '0 : r_phase + t_phase'(1);
                                if (r_col == COL_W'(COLUMNS - 1)) begin
                                    n_col = '0;
                                    n_row = r_row + ROW_W'(1);
                                end else begin
                                    n_col = r_col + COL_W'(1);
                                end
                            end
                            n_pos = OFF_W'(wide_pos);
                            // ran off the end of the screen: home to last row, scroll
                            if (wide_pos >= WIDE_W'(CELLS)) begin
                                n_pos      = OFF_W'(CELLS - COLUMNS);
                                n_col      = '0;
                                n_row      = ROW_W'(ROWS - 1);
                                n_phase    = ROW_PHASE[ROWS-1];
                                n_scrolled = 1'b1;
                                n_state    = S_SCR_RD;
                            end
                        end
                        F_SET: begin
                            n_pos   = OFF_W'(py_c * COLUMNS) + OFF_W'(px_c);
                            n_col   = px_c;
                            n_row   = py_c;
                            n_phase = (set_phase >= (PH_W + 1)'(TAB_STOP)) ?
                                      t_phase'(set_phase - (PH_W + 1)'(TAB_STOP)) :
                                      t_phase'(set_phase);
                        end
                        F_CLEAR: begin
                            n_pos   = '0;
                            n_col   = '0;
                            n_row   = '0;
                            n_phase = '0;
                            n_idx   = '0;
                            n_state = S_BLANK;
                        end
                        F_READ: begin
                            n_rd_ok = (i_cell_addr < OFF_W'(CELLS));
                            n_state = S_READ;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_rd_data = r_rd_ok ? ram_rdata : '0;
                n_state   = S_RESP;
            end
            S_SCR_RD: begin
                ram_raddr = ADDR_W'(COLUMNS);
                n_idx     = '0;
                n_state   = S_SCR_MV;
            end
            S_SCR_MV: begin
                // row move: read one row ahead, write the word back in the next cycle
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = ram_rdata;
                if (r_idx == ADDR_W'(CELLS - COLUMNS - 1)) begin
                    n_idx   = ADDR_W'(CELLS - COLUMNS);
                    n_state = S_BLANK;
                end else begin
                    ram_raddr = r_idx + ADDR_W'(COLUMNS + 1);
                    n_idx     = r_idx + ADDR_W'(1);
                end
            end
            S_BLANK: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = {CH_SPACE, r_attr};
                n_idx     = r_idx + ADDR_W'(1);
                if (r_idx == ADDR_W'(CELLS - 1)) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = (r_state == S_RESP);
    assign o_cursor_offset = r_pos;
    assign o_cursor_col    = r_col;
    assign o_cursor_row    = r_row;
    assign o_scrolled      = r_scrolled;
    assign o_read_char     = r_rd_data[CELL_W-1:ATTR_W];
    assign o_read_attr     = r_rd_data[ATTR_W-1:0];

endmodule

// File: design/tcw_checker.sv
// tcw_checker: port-level assertions for text_console_writer_unit, bound below
// depends on tcw_pkg
module tcw_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_valid,
    input logic [tcw_pkg::OFF_W-1:0]   o_cursor_offset,
    input logic [tcw_pkg::COL_W-1:0]   o_cursor_col,
    input logic [tcw_pkg::ROW_W-1:0]   o_cursor_row,
    input logic                        o_scrolled
);

    import tcw_pkg::*;

    // an accepted word always raises busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // the result word is shown exactly one cycle
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    // cursor stays on screen and offset agrees with row and column
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cursor_col < COL_W'(COLUMNS)) && (o_cursor_row < ROW_W'(ROWS))
            && (o_cursor_offset == OFF_W'(o_cursor_row * COLUMNS) + OFF_W'(o_cursor_col)))
        else $error("cursor off screen or inconsistent");

    // a scroll always leaves the cursor at the start of the last row
    a_scroll_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_scrolled) |-> (o_cursor_row == ROW_W'(ROWS - 1))
            && (o_cursor_col == '0))
        else $error("scroll did not home cursor to last row");

endmodule

bind text_console_writer_unit tcw_checker u_tcw_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_valid         (o_valid),
    .o_cursor_offset (o_cursor_offset),
    .o_cursor_col    (o_cursor_col),
    .o_cursor_row    (o_cursor_row),
    .o_scrolled      (o_scrolled)
);

// File: tb/console_result_checker.sv
// console_result_checker: watches the command and result channels of the text console writer,
// keeps a shadow screen, cursor and attribute, and scores every result word in order
// depends on tcw_pkg
module console_result_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_busy,
    input  logic [tcw_pkg::FUNC_W-1:0] i_func,
    input  logic [tcw_pkg::CHAR_W-1:0] i_char_code,
    input  logic [tcw_pkg::COL_W-1:0]  i_pos_x,
    input  logic [tcw_pkg::ROW_W-1:0]  i_pos_y,
    input  logic [tcw_pkg::OFF_W-1:0]  i_cell_addr,
    input  logic                       i_cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0] i_cfg_wdata,
    input  logic                       i_valid,
    input  logic [tcw_pkg::OFF_W-1:0]  i_cursor_offset,
    input  logic [tcw_pkg::COL_W-1:0]  i_cursor_col,
    input  logic [tcw_pkg::ROW_W-1:0]  i_cursor_row,
    input  logic                       i_scrolled,
    input  logic [tcw_pkg::CHAR_W-1:0] i_read_char,
    input  logic [tcw_pkg::ATTR_W-1:0] i_read_attr,
    output int                         o_fail_count,
    output int                         o_pending
);

    import tcw_pkg::*;

    typedef struct packed {
        logic [OFF_W-1:0]  offset;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              scrolled;
        logic [CHAR_W-1:0] rchar;
        logic [ATTR_W-1:0] rattr;
    } t_cursor_word;

    logic [CHAR_W-1:0] shadow_chars [CELLS];
    logic [ATTR_W-1:0] shadow_attrs [CELLS];
    int                shadow_cursor = 0;
    logic [ATTR_W-1:0] shadow_attr = ATTR_RESET;

    t_cursor_word cursor_reports_due [$];
    int           mismatch_count = 0;
    int           due_count = 0;

    assign o_fail_count = mismatch_count;
    assign o_pending    = due_count;

    // runs one console operation on the shadow screen and returns the word it reports
    function automatic t_cursor_word apply_console_op(
        input t_func             op,
        input logic [CHAR_W-1:0] ch,
        input logic [COL_W-1:0]  px,
        input logic [ROW_W-1:0]  py,
        input logic [OFF_W-1:0]  addr
    );
        t_cursor_word w;
        int           p;
        int           cx;
        int           cy;
        int           i;
        w = '0;
        if (shadow_cursor >= CELLS) begin
            shadow_cursor = CELLS - 1;
        end
        p = shadow_cursor;
        case (op)
            F_PRINT: begin
                if (ch == CH_NEWLINE) begin
                    p = p + COLUMNS - (p % COLUMNS);
                end else if (ch == CH_TAB) begin
                    p = p + TAB_STOP - (p % TAB_STOP);
                end else begin
                    shadow_chars[p] = ch;
                    shadow_attrs[p] = shadow_attr;
                    p = p + 1;
                end
                // end of screen: rows move up, last row blanked
                if (p >= CELLS) begin
                    for (i = 0; i < CELLS - COLUMNS; i++) begin
                        shadow_chars[i] = shadow_chars[i + COLUMNS];
                        shadow_attrs[i] = shadow_attrs[i + COLUMNS];
                    end
                    for (i = CELLS - COLUMNS; i < CELLS; i++) begin
                        shadow_chars[i] = CH_SPACE;
                        shadow_attrs[i] = shadow_attr;
                    end
                    p = CELLS - COLUMNS;
                    w.scrolled = 1'b1;
                end
            end
            F_SET: begin
                cx = (px > COLUMNS - 1) ? COLUMNS - 1 : int'(px);
                cy = (py > ROWS - 1) ? ROWS - 1 : int'(py);
                p = cy * COLUMNS + cx;
            end
            F_CLEAR: begin
                for (i = 0; i < CELLS; i++) begin
                    shadow_chars[i] = CH_SPACE;
                    shadow_attrs[i] = shadow_attr;
                end
                p = 0;
            end
            default: begin
                if (addr < CELLS) begin
                    w.rchar = shadow_chars[addr];
                    w.rattr = shadow_attrs[addr];
                end
            end
        endcase
        shadow_cursor = p;
        w.offset = OFF_W'(p);
        w.col    = COL_W'(p % COLUMNS);
        w.row    = ROW_W'(p / COLUMNS);
        return w;
    endfunction

    task automatic log_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_cursor_word got;
        t_cursor_word want;
        if (!i_rst_n) begin
            shadow_cursor = 0;
            shadow_attr   = ATTR_RESET;
            cursor_reports_due.delete();
        end else begin
            if (i_valid) begin
                got = '{i_cursor_offset, i_cursor_col, i_cursor_row, i_scrolled,
                        i_read_char, i_read_attr};
                if (cursor_reports_due.size() == 0) begin
                    log_failure($sformatf(
                        "result word with no command pending: off %0d col %0d row %0d",
                        got.offset, got.col, got.row));
                end else begin
                    want = cursor_reports_due.pop_front();
                    if (got !== want) begin
                        log_failure($sformatf({"word mismatch: want off %0d col %0d row %0d ",
                            "scr %0d char %02h attr %02h, got off %0d col %0d row %0d ",
                            "scr %0d char %02h attr %02h"},
                            want.offset, want.col, want.row, want.scrolled, want.rchar,
                            want.rattr, got.offset, got.col, got.row, got.scrolled,
                            got.rchar, got.rattr));
                    end
                end
            end
            if (i_cfg_we) begin
                shadow_attr = i_cfg_wdata;
            end
            if (i_start && !i_busy) begin
                cursor_reports_due.push_back(apply_console_op(t_func'(i_func), i_char_code,
                    i_pos_x, i_pos_y, i_cell_addr));
            end
        end
        due_count = cursor_reports_due.size();
    end

endmodule

// File: tb/text_console_writer_unit_test.sv
// text_console_writer_unit_test: drives console commands and attribute writes into
// text_console_writer_unit and gives the verdict from console_result_checker; needs tcw_pkg
module text_console_writer_unit_test;
    import tcw_pkg::*;

    localparam int RANDOM_WORDS = 1650;
    localparam int PHASES       = 5;
    localparam int DRAIN_CYCLES = 64;
    localparam int TIMEOUT_TIME = 100_000_000;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [FUNC_W-1:0] i_func;
    logic [CHAR_W-1:0] i_char_code;
    logic [COL_W-1:0]  i_pos_x;
    logic [ROW_W-1:0]  i_pos_y;
    logic [OFF_W-1:0]  i_cell_addr;
    logic              i_cfg_we;
    logic [ATTR_W-1:0] i_cfg_wdata;
    logic              o_valid;
    logic [OFF_W-1:0]  o_cursor_offset;
    logic [COL_W-1:0]  o_cursor_col;
    logic [ROW_W-1:0]  o_cursor_row;
    logic              o_scrolled;
    logic [CHAR_W-1:0] o_read_char;
    logic [ATTR_W-1:0] o_read_attr;

    int fail_count;
    int words_due;
    int burst_left = 0;

    always #5 i_clk = ~i_clk;

    text_console_writer_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_char_code     (i_char_code),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_cell_addr     (i_cell_addr),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_valid         (o_valid),
        .o_cursor_offset (o_cursor_offset),
        .o_cursor_col    (o_cursor_col),
        .o_cursor_row    (o_cursor_row),
        .o_scrolled      (o_scrolled),
        .o_read_char     (o_read_char),
        .o_read_attr     (o_read_attr)
    );

    console_result_checker console_watch (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_func          (i_func),
        .i_char_code     (i_char_code),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_cell_addr     (i_cell_addr),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (o_valid),
        .i_cursor_offset (o_cursor_offset),
        .i_cursor_col    (o_cursor_col),
        .i_cursor_row    (o_cursor_row),
        .i_scrolled      (o_scrolled),
        .i_read_char     (o_read_char),
        .i_read_attr     (o_read_attr),
        .o_fail_count    (fail_count),
        .o_pending       (words_due)
    );

    // idle cycles before the next command; occasional back-to-back bursts
    function automatic int draw_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            burst_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 7);
    endfunction

    // start stays high into the next command when no gap is drawn
    task automatic send_command(input t_func op, input logic [CHAR_W-1:0] ch,
                                input logic [COL_W-1:0] px, input logic [ROW_W-1:0] py,
                                input logic [OFF_W-1:0] addr);
        int gap;
        gap = draw_gap();
        @(negedge i_clk);
        start       <= 1'b1;
        i_func      <= op;
        i_char_code <= ch;
        i_pos_x     <= px;
        i_pos_y     <= py;
        i_cell_addr <= addr;
        do @(posedge i_clk); while (busy);
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        start <= 1'b0;
        while (words_due != 0 || busy) @(negedge i_clk);
    endtask

    task automatic write_attribute(input logic [ATTR_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        #(TIMEOUT_TIME);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        logic [ATTR_W-1:0] attr_plan [PHASES];
        t_func             op;
        logic [CHAR_W-1:0] ch;
        logic [COL_W-1:0]  px;
        logic [ROW_W-1:0]  py;
        logic [OFF_W-1:0]  addr;
        int                r;
        bit                screen_valid;

        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_func      = F_PRINT;
        i_char_code = '0;
        i_pos_x     = '0;
        i_pos_y     = '0;
        i_cell_addr = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        screen_valid = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset attribute; only off-screen reads until the first clear
        send_command(F_READ, 8'h00, 7'd0, 5'd0, 11'd2047);
        send_command(F_READ, 8'h00, 7'd0, 5'd0, 11'(CELLS));
        send_command(F_CLEAR, 8'h00, 7'd0, 5'd0, 11'd0);
        send_command(F_READ, 8'h00, 7'd0, 5'd0, 11'd0);
        send_command(F_READ, 8'h00, 7'd0, 5'd0, 11'(CELLS - 1));
        send_command(F_PRINT, 8'h41, 7'd0, 5'd0, 11'd0);
        send_command(F_READ, 8'h00, 7'd0, 5'd0, 11'd0);
        screen_valid = 1'b1;

        wait_idle();
        write_attribute(8'hFF);
        send_command(F_PRINT, 8'h00, 7'd0, 5'd0, 11'd0);
        send_command(F_PRINT, 8'hFF, 7'd0, 5'd0, 11'd0);
        send_command(F_PRINT, CH_TAB, 7'd0, 5'd0, 11'd0);
        send_command(F_PRINT, CH_NEWLINE, 7'd0, 5'd0, 11'd0);
        send_command(F_READ, 8'h00, 7'd0, 5'd0, 11'd1);
        send_command(F_READ, 8'h00, 7'd0, 5'd0, 11'd2);
        send_command(F_SET, 8'h00, 7'd0, 5'd0, 11'd0);
        send_command(F_SET, 8'h00, 7'd127, 5'd31, 11'd0);
        send_command(F_SET, 8'h00, 7'(COLUMNS), 5'(ROWS), 11'd0);
        send_command(F_SET, 8'h00, 7'(COLUMNS - 1), 5'(ROWS - 1), 11'd0);
        // last cell, tab and newline on the bottom row all scroll
        send_command(F_PRINT, 8'h5A, 7'd0, 5'd0, 11'd0);
        send_command(F_READ, 8'h00, 7'd0, 5'd0, 11'(CELLS - 1));
        send_command(F_SET, 8'h00, 7'd72, 5'(ROWS - 1), 11'd0);
        send_command(F_PRINT, CH_TAB, 7'd0, 5'd0, 11'd0);
        send_command(F_SET, 8'h00, 7'd5, 5'(ROWS - 1), 11'd0);
        send_command(F_PRINT, CH_NEWLINE, 7'd0, 5'd0, 11'd0);
        send_command(F_READ, 8'h00, 7'd0, 5'd0, 11'(CELLS - COLUMNS - 1));

        attr_plan[0] = 8'h00;
        attr_plan[1] = ATTR_W'($urandom_range(1, 254));
        attr_plan[2] = 8'hFF;
        attr_plan[3] = ATTR_W'($urandom_range(0, 255));
        attr_plan[4] = 8'h80;

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            write_attribute(attr_plan[ph]);
            for (int n = 0; n < RANDOM_WORDS / PHASES; n++) begin
                ch   = CHAR_W'($urandom_range(0, 255));
                px   = COL_W'($urandom_range(0, 127));
                py   = ROW_W'($urandom_range(0, 31));
                addr = OFF_W'($urandom_range(0, 2047));
                r = $urandom_range(0, 99);
                if (r < 52) begin
                    op = F_PRINT;
                    case ($urandom_range(0, 15))
                        0: ch = CH_NEWLINE;
                        1: ch = CH_TAB;
                        default: ;
                    endcase
                end else if (r < 72) begin
                    op = F_SET;
                    // lean toward the bottom right so prints run into a scroll
                    r = $urandom_range(0, 19);
                    if (r < 3) begin
                        px = COL_W'($urandom_range(COLUMNS, 127));
                    end else if (r < 7) begin
                        px = COL_W'($urandom_range(COLUMNS - 10, COLUMNS - 1));
                    end else begin
                        px = COL_W'($urandom_range(0, COLUMNS - 1));
                    end
                    r = $urandom_range(0, 9);
                    if (r < 4) begin
                        py = ROW_W'(ROWS - 1);
                    end else if (r == 4) begin
                        py = ROW_W'($urandom_range(ROWS, 31));
                    end else begin
                        py = ROW_W'($urandom_range(0, ROWS - 1));
                    end
                end else if (r < 74) begin
                    op = F_CLEAR;
                    screen_valid = 1'b1;
                end else begin
                    op = F_READ;
                    if (!screen_valid) begin
                        addr = OFF_W'($urandom_range(CELLS, 2047));
                    end else if ($urandom_range(0, 9) != 0) begin
                        addr = OFF_W'($urandom_range(0, CELLS - 1));
                    end
                end
                send_command(op, ch, px, py, addr);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && words_due == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
